/* design/inode_bitmap_allocator_core_macros.svh */
// ---------------------------------------------------------------------------
// Inode bitmap allocator assertion macros
// Shared concurrent assertion forms for the checker.
// ---------------------------------------------------------------------------
`ifndef INODE_BITMAP_ALLOCATOR_CORE_MACROS_SVH
`define INODE_BITMAP_ALLOCATOR_CORE_MACROS_SVH

// same-cycle implication
`define IBM_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define IBM_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/ibm_pkg.sv */
// ---------------------------------------------------------------------------
// Inode bitmap allocator package
// Field widths, offset limit, status and command codes, register indexes.
// ---------------------------------------------------------------------------
package ibm_pkg;

  localparam int CNT_W      = 13;
  localparam int NUM_W      = 16;
  localparam int BLK_W      = 8;
  localparam int OFS_W      = 20;
  localparam int WORD_BITS  = 32;
  localparam int WIDX_W     = CNT_W - 5;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 40;

  localparam logic [OFS_W-1:0] OFFSET_MAX = 20'hFFFFF;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [1:0] REG_FS_VALID    = 2'd0;
  localparam logic [1:0] REG_INODE_COUNT = 2'd1;
  localparam logic [1:0] REG_IMAP_BLOCKS = 2'd2;
  localparam logic [1:0] REG_ZMAP_BLOCKS = 2'd3;

endpackage

/* design/inode_bitmap_allocator_core.sv */
// ---------------------------------------------------------------------------
// Inode bitmap allocator core
// First-fit inode allocation and release over a use bitmap held in RAM.
// ---------------------------------------------------------------------------
// Requests enter on the s_axis channel (tuser = cmd, tdata = inode number);
// each gives exactly one result on m_axis (tuser = status, tdata = granted
// inode and disk offset). One request is in work at a time.
// Allocate scans the map one 32-bit RAM word per cycle through the single
// read port. A full map answers once the last word is checked; a grant
// first passes the slot split (S_DIV) and the offset multiply and add
// (S_MUL, S_SUM). Free is a read-modify-write of one word (S_F_RD then
// S_F_WR). Rejected requests go straight to S_RESP. The next request
// is taken in the cycle the previous result appears.
// After reset the map is cleared by a pass of (MAX_INODES + 31) / 32 words, one
// per cycle, with s_axis_tready_o low; configuration writes are taken as
// ever. The result sits in an output register: the next request is taken
// while it waits, and a stalled receiver holds the core only when a second
// result is ready.
// ---------------------------------------------------------------------------
module inode_bitmap_allocator_core #(
  parameter int MAX_INODES  = 4096,
  parameter int BLOCK_BYTES = 1024,
  parameter int INODE_BYTES = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [1:0]                        cfg_idx_i,
  input  logic [ibm_pkg::CNT_W-1:0]         cfg_wdata_i,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // [15:0] inode_number
  input  logic [ibm_pkg::IN_DATA_W-1:0]     s_axis_tdata_i,
  // [0] cmd
  input  logic                              s_axis_tuser_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // [12:0] granted_inode, [32:13] disk_offset, [39:33] zero
  output logic [ibm_pkg::OUT_DATA_W-1:0]    m_axis_tdata_o,
  // [1:0] status
  output logic [1:0]                        m_axis_tuser_o
);

  import ibm_pkg::*;

  localparam int WORDS     = (MAX_INODES + 31) / 32;
  localparam int AW        = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int PER_RAW   = BLOCK_BYTES / INODE_BYTES;
  localparam int PER_BLOCK = (PER_RAW > 0) ? PER_RAW : 1;
  localparam int RW        = $clog2(PER_BLOCK) + 1;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_A_RD, S_A_CHK, S_F_RD, S_F_WR, S_DIV, S_MUL, S_SUM, S_RESP
  } state_e;

  state_e            state_q;
  logic              fs_valid_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [BLK_W-1:0]  imap_q, zmap_q;
  logic [AW-1:0]     clr_q;
  logic [WIDX_W-1:0] wcnt_q;
  logic [CNT_W-1:0]  bit_q;
  logic [1:0]        res_status_q;
  logic [CNT_W-1:0]  res_inode_q;
  logic [OFS_W-1:0]  res_offset_q;
  logic [31:0]       prod_blk_q, prod_slot_q;
  logic              out_valid_q;
  logic [1:0]        out_status_q;
  logic [CNT_W-1:0]  out_inode_q;
  logic [OFS_W-1:0]  out_offset_q;

  logic [CNT_W-1:0]  act_cnt;
  logic              s_fire;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [31:0]       ram_wdata, ram_rdata;
  logic [CNT_W-1:0]  rem_bits;
  logic [31:0]       word_mask, avail;
  logic              hit;
  logic [4:0]        first_k;
  logic              last_word;
  logic              div_start, div_done;
  logic [CNT_W-1:0]  div_quot;
  logic [RW-1:0]     div_rem;
  logic [CNT_W:0]    blk_idx;
  logic [32:0]       ofs_sum;
  logic [NUM_W-1:0]  num_dec;
  logic              out_free;

  assign act_cnt = (32'(cnt_q) > 32'(MAX_INODES)) ? CNT_W'(MAX_INODES) : cnt_q;
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign s_fire   = s_axis_tvalid_i && s_axis_tready_o;
  assign num_dec  = s_axis_tdata_i - NUM_W'(1);
  assign out_free = !out_valid_q || m_axis_tready_i;

  assign rem_bits  = act_cnt - {wcnt_q, 5'b0};
  assign word_mask = (rem_bits >= CNT_W'(WORD_BITS)) ? '1 : ~(32'hFFFF_FFFF << rem_bits[4:0]);
  assign avail     = ~ram_rdata & word_mask;
  assign hit       = |avail;
  assign last_word = ({1'b0, wcnt_q, 5'b0} + 14'd32) >= {1'b0, act_cnt};

  always_comb begin
    first_k = '0;
    for (int k = WORD_BITS - 1; k >= 0; k--) begin
      if (avail[k]) begin
        first_k = 5'(k);
      end
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = AW'(wcnt_q);
    ram_wdata = ram_rdata;
    ram_raddr = AW'(wcnt_q);
    case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
      end
      S_A_CHK: begin
        ram_raddr = AW'(wcnt_q + WIDX_W'(1));
        ram_we    = hit;
        ram_wdata = ram_rdata | (32'd1 << first_k);
      end
      S_F_RD: begin
        ram_raddr = AW'(bit_q[CNT_W-1:5]);
      end
      S_F_WR: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(bit_q[CNT_W-1:5]);
        ram_wdata = ram_rdata & ~(32'd1 << bit_q[4:0]);
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  assign div_start = (state_q == S_A_CHK) && hit;
  assign blk_idx   = (CNT_W + 1)'(2) + (CNT_W + 1)'(imap_q) + (CNT_W + 1)'(zmap_q)
                   + (CNT_W + 1)'(div_quot);
  assign ofs_sum   = 33'(prod_blk_q) + 33'(prod_slot_q);

  ibm_map_ram #(
    .WORDS (WORDS),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  ibm_slot_div #(
    .DIVISOR (PER_BLOCK),
    .RW      (RW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({wcnt_q, first_k}),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fs_valid_q <= 1'b0;
      cnt_q      <= '0;
      imap_q     <= '0;
      zmap_q     <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_FS_VALID:    fs_valid_q <= cfg_wdata_i[0];
        REG_INODE_COUNT: cnt_q      <= cfg_wdata_i;
        REG_IMAP_BLOCKS: imap_q     <= cfg_wdata_i[BLK_W-1:0];
        REG_ZMAP_BLOCKS: zmap_q     <= cfg_wdata_i[BLK_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (m_axis_tready_i && state_q != S_RESP) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + AW'(1);
          if (clr_q == AW'(WORDS - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_fire) begin
            res_inode_q  <= '0;
            res_offset_q <= '0;
            wcnt_q       <= '0;
            bit_q        <= CNT_W'(num_dec);
            if (!fs_valid_q) begin
              res_status_q <= ST_INVALID;
              state_q      <= S_RESP;
            end else if (s_axis_tuser_i == CMD_ALLOC) begin
              if (act_cnt == '0) begin
                res_status_q <= ST_FULL;
                state_q      <= S_RESP;
              end else begin
                res_status_q <= ST_OK;
                state_q      <= S_A_RD;
              end
            end else if (s_axis_tdata_i == '0 ||
                         s_axis_tdata_i > NUM_W'(act_cnt)) begin
              res_status_q <= ST_INVALID;
              state_q      <= S_RESP;
            end else begin
              res_status_q <= ST_OK;
              state_q      <= S_F_RD;
            end
          end
        end
        S_A_RD: begin
          state_q <= S_A_CHK;
        end
        S_A_CHK: begin
          if (hit) begin
            res_inode_q <= {wcnt_q, first_k} + CNT_W'(1);
            state_q     <= S_DIV;
          end else if (last_word) begin
            res_status_q <= ST_FULL;
            state_q      <= S_RESP;
          end else begin
            wcnt_q <= wcnt_q + WIDX_W'(1);
          end
        end
        S_F_RD: begin
          state_q <= S_F_WR;
        end
        S_F_WR: begin
          state_q <= S_RESP;
        end
        S_DIV: begin
          if (div_done) begin
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          prod_blk_q  <= 32'(blk_idx) * 32'(BLOCK_BYTES);
          prod_slot_q <= 32'(div_rem) * 32'(INODE_BYTES);
          state_q     <= S_SUM;
        end
        S_SUM: begin
          res_offset_q <= (ofs_sum > 33'(OFFSET_MAX)) ? OFFSET_MAX : ofs_sum[OFS_W-1:0];
          state_q      <= S_RESP;
        end
        S_RESP: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_status_q <= res_status_q;
            out_inode_q  <= res_inode_q;
            out_offset_q <= res_offset_q;
            state_q      <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tdata_o  = {(OUT_DATA_W - CNT_W - OFS_W)'(0), out_offset_q, out_inode_q};

endmodule

/* design/ibm_map_ram.sv */
// ---------------------------------------------------------------------------
// Inode map RAM
// One write port and one read port, 32-bit words, registered read data.
// ---------------------------------------------------------------------------
module ibm_map_ram #(
  parameter int WORDS = 128,
  parameter int AW    = 7
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [31:0]   wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [31:0]   rdata_o
);

  logic [31:0] mem [WORDS];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

/* design/ibm_slot_div.sv */
// ---------------------------------------------------------------------------
// Inode slot divider
// Splits a bit index into block and slot by a fixed divisor, using a
// registered reciprocal multiply, then a registered back-multiply.
// ---------------------------------------------------------------------------
module ibm_slot_div #(
  parameter int DIVISOR = 32,
  parameter int RW      = 6
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [ibm_pkg::CNT_W-1:0] dividend_i,
  output logic                   done_o,
  output logic [ibm_pkg::CNT_W-1:0] quot_o,
  output logic [RW-1:0]          rem_o
);

  import ibm_pkg::*;

  localparam int LOG_D   = (DIVISOR > 1) ? $clog2(DIVISOR) : 0;
  localparam int SHIFT   = CNT_W + LOG_D;
  localparam int RECIP_W = CNT_W + 2;
  localparam int PROD_W  = CNT_W + RECIP_W;
  localparam longint unsigned RECIP =
    ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);

  logic              stage_q;
  logic              done_q;
  logic [CNT_W-1:0]  num_q;
  logic [PROD_W-1:0] prod_q;
  logic [CNT_W-1:0]  quot_q;
  logic [RW-1:0]     rem_q;
  logic [CNT_W-1:0]  quot;
  logic [CNT_W-1:0]  back;

  assign quot = CNT_W'(prod_q >> SHIFT);
  assign back = quot * CNT_W'(DIVISOR);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      stage_q <= start_i;
      done_q  <= stage_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q  <= dividend_i;
      prod_q <= PROD_W'(dividend_i) * PROD_W'(RECIP);
    end
    if (stage_q) begin
      quot_q <= quot;
      rem_q  <= RW'(num_q - back);
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

/* design/ibm_checker.sv */
// ---------------------------------------------------------------------------
// Inode bitmap allocator checker
// Port-level properties of the core, attached by bind.
// ---------------------------------------------------------------------------
`include "inode_bitmap_allocator_core_macros.svh"

module ibm_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid_i,
  input logic                           s_axis_tready_o,
  input logic                           m_axis_tvalid_o,
  input logic                           m_axis_tready_i,
  input logic [ibm_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  input logic [1:0]                     m_axis_tuser_o
);

  import ibm_pkg::*;

  `IBM_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i,
    m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o),
    "stalled result changed")
  `IBM_ASSERT_NOW(a_status_code, clk_i, rst_ni, m_axis_tvalid_o,
    m_axis_tuser_o == ST_OK || m_axis_tuser_o == ST_INVALID || m_axis_tuser_o == ST_FULL,
    "undefined status code")
  `IBM_ASSERT_NOW(a_reject_empty, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tuser_o != ST_OK,
    m_axis_tdata_o == '0, "rejected request carries data")
  `IBM_ASSERT_NEXT(a_one_in_work, clk_i, rst_ni, s_axis_tvalid_i && s_axis_tready_o,
    !s_axis_tready_o, "second request taken while one is in work")

endmodule

bind inode_bitmap_allocator_core ibm_checker u_ibm_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
